@@ rtl/rtnc_pkg.sv @@
// Shared types, constants and the tile classification function of the river tile classifier.
package rtnc_pkg;

    // Sizes of the line buffers and of the configuration fields.
    localparam int MAX_COLUMNS   = 4096;
    localparam int COL_BITS      = $clog2(MAX_COLUMNS);
    localparam int CODE_BITS     = 4;
    localparam int WIDTH_BITS    = 13;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [CODE_BITS-1:0]   t_code;
    typedef logic [COL_BITS-1:0]    t_col;
    typedef logic [WIDTH_BITS-1:0]  t_width;
    typedef logic [HEIGHT_BITS-1:0] t_row;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    // Tile codes.
    localparam t_code C_RIVER    = t_code'(1);
    localparam t_code C_NW_BEND  = t_code'(2);
    localparam t_code C_SW_BEND  = t_code'(3);
    localparam t_code C_NE_BEND  = t_code'(4);
    localparam t_code C_SE_BEND  = t_code'(5);
    localparam t_code C_NES_FORK = t_code'(6);
    localparam t_code C_NSW_FORK = t_code'(7);
    localparam t_code C_WNE_FORK = t_code'(8);
    localparam t_code C_WSE_FORK = t_code'(9);
    localparam t_code C_FOUR_WAY = t_code'(10);

    // One line buffer entry: the cell two rows back and the cell one row back.
    typedef struct packed {
        t_code upper;
        t_code middle;
    } t_line_entry;

    // Control word of one accepted item, passed from the sequencer to the data stage.
    typedef struct packed {
        logic  emit;
        logic  tile;
        logic  top_ok;
        logic  left_ok;
        logic  right_ok;
        logic  last;
        t_code code;
        t_col  col;
    } t_item;

    // Rewrite a tile from its river neighbours; the most specific pattern wins.
    function automatic t_code classify(input t_code centre, input logic t, input logic b,
                                       input logic l, input logic r);
        t_code v;
        v = centre;
        if (centre >= C_RIVER) begin
            priority if (r && l && b && t) v = C_FOUR_WAY;
            else if (r && l && b)         v = C_WSE_FORK;
            else if (r && l && t)         v = C_WNE_FORK;
            else if (b && l && t)         v = C_NSW_FORK;
            else if (b && r && t)         v = C_NES_FORK;
            else if (b && r)              v = C_SE_BEND;
            else if (t && r)              v = C_NE_BEND;
            else if (l && b)              v = C_SW_BEND;
            else if (t && l)              v = C_NW_BEND;
            else                          v = centre;
        end
        return v;
    endfunction

endpackage

@@ rtl/rtnc_line_mem.sv @@
// Line buffer memory: one write port, two registered read ports, write-to-read forwarding.
module rtnc_line_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  rtnc_pkg::t_col       i_rd_addr_a,
    input  rtnc_pkg::t_col       i_rd_addr_b,
    input  logic                 i_wr_en,
    input  rtnc_pkg::t_col       i_wr_addr,
    input  rtnc_pkg::t_line_entry i_wr_data,
    output rtnc_pkg::t_line_entry o_rd_entry,
    output rtnc_pkg::t_code      o_rd_right
);
    import rtnc_pkg::*;

    t_line_entry r_mem [MAX_COLUMNS];
    t_line_entry r_rd_a;
    t_code       r_rd_b;
    t_line_entry r_fwd_data;
    logic        r_fwd_a;
    logic        r_fwd_b;

    // Storage array with read-before-write behavior on both read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a     <= r_mem[i_rd_addr_a];
            r_rd_b     <= r_mem[i_rd_addr_b].middle;
            r_fwd_data <= i_wr_data;
        end
    end

    // A write in the same cycle as a read of that entry is forwarded past the array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_a <= i_wr_en && (i_wr_addr == i_rd_addr_a);
            r_fwd_b <= i_wr_en && (i_wr_addr == i_rd_addr_b);
        end
    end

    assign o_rd_entry = r_fwd_a ? r_fwd_data : r_rd_a;
    assign o_rd_right = r_fwd_b ? r_fwd_data.middle : r_rd_b;

endmodule

@@ rtl/rtnc_ctrl.sv @@
// Grid sequencer: configuration registers, column and row counters, per-item control word.
module rtnc_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rtnc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [rtnc_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_accept,
    input  logic                                 i_mode,
    input  rtnc_pkg::t_code                      i_tile_code,
    output logic                                 o_take,
    output rtnc_pkg::t_item                      o_item,
    output rtnc_pkg::t_col                       o_right_addr
);
    import rtnc_pkg::*;

    t_width r_width;
    t_row   r_height;
    t_col   r_col;
    t_col   n_col;
    t_row   r_row;
    t_row   n_row;

    t_width w_eff;
    t_row   h_eff;
    t_col   col_eff;
    t_row   row_eff;
    t_width col_next;
    logic   at_end;
    t_row   out_row;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= t_width'(1);
            r_height <= t_row'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_WIDTH:  r_width  <= i_cfg_wdata[WIDTH_BITS-1:0];
                CFG_GRID_HEIGHT: r_height <= i_cfg_wdata[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the settings and counters into their legal ranges.
    always_comb begin
        if (r_width == '0) begin
            w_eff = t_width'(1);
        end else if (r_width > t_width'(MAX_COLUMNS)) begin
            w_eff = t_width'(MAX_COLUMNS);
        end else begin
            w_eff = r_width;
        end
        h_eff    = (r_height == '0) ? t_row'(1) : r_height;
        col_eff  = ({1'b0, r_col} >= w_eff) ? '0 : r_col;
        row_eff  = (r_row > h_eff) ? h_eff : r_row;
        col_next = {1'b0, col_eff} + t_width'(1);
        at_end   = col_next >= w_eff;
    end

    // Decide whether the item is taken and build its control word.
    always_comb begin
        o_item      = '0;
        o_item.tile = !i_mode;
        o_item.code = i_tile_code;
        o_item.col  = col_eff;
        if (!i_mode) begin
            o_take      = row_eff < h_eff;
            o_item.emit = row_eff != '0;
            out_row     = (row_eff != '0) ? row_eff - t_row'(1) : '0;
        end else begin
            o_take      = row_eff == h_eff;
            o_item.emit = 1'b1;
            out_row     = h_eff - t_row'(1);
        end
        o_item.top_ok   = out_row != '0;
        o_item.left_ok  = col_eff != '0;
        o_item.right_ok = !at_end;
        o_item.last     = (out_row == h_eff - t_row'(1)) && at_end;
    end

    assign o_right_addr = col_next[COL_BITS-1:0];

    // Every accepted item stores the clamped counters; a taken item also advances them,
    // and a flush of the last column ends the frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            n_col = col_eff;
            n_row = row_eff;
            if (o_take) begin
                if (at_end) begin
                    n_col = '0;
                    n_row = i_mode ? '0 : row_eff + t_row'(1);
                end else begin
                    n_col = col_next[COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ rtl/river_tile_neighbour_classifier_top.sv @@
// Top level of the river tile classifier: sequencer, line buffer and classify stage.
//
// Input channel: i_in_valid / o_in_stall with i_mode and i_tile_code. A tile item
// (mode 0) carries the next cell in raster order; a flush item (mode 1) drains one
// column of the last row once all rows of the frame are in.
// Output channel: o_out_valid / i_out_stall with o_class_code and o_last_of_frame.
// Each result is the rewritten code of the cell one row above the incoming item,
// so results lag the input by one grid row; tiles of the first row give none.
// The user must write grid_width and grid_height on the configuration port only
// while the block idles; the block does not check it. Throughput is one item per
// cycle without stalls. An item is read from the line buffer at its transfer,
// classified in the next cycle and enters the output register when it advances;
// the line buffer write-back of one item and the read of the next share a cycle.
// Reset clears the counters and sets width and height to 1; the line buffers are
// not cleared. When the receiver stalls, the result waits in the output register,
// the classify stage holds its item, and o_in_stall rises once both are full.
module river_tile_neighbour_classifier_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rtnc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [rtnc_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic [rtnc_pkg::CODE_BITS-1:0]       i_tile_code,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [rtnc_pkg::CODE_BITS-1:0]       o_class_code,
    output logic                                 o_last_of_frame
);
    import rtnc_pkg::*;

    logic        accept;
    logic        take;
    t_item       item;
    t_col        right_addr;

    logic        r_s1_valid;
    logic        n_s1_valid;
    t_item       r_s1_item;
    logic        s1_adv;
    logic        out_free;

    t_line_entry rd_entry;
    t_code       rd_right;
    t_line_entry wr_data;
    t_code       r_left;

    t_code       centre;
    logic        nb_t;
    logic        nb_b;
    logic        nb_l;
    logic        nb_r;

    logic        r_out_valid;
    t_code       r_class;
    logic        r_last;

    // Handshake: the classify stage moves on unless its result meets a full, stalled output.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!r_s1_item.emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    rtnc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_tile_code  (i_tile_code),
        .o_take       (take),
        .o_item       (item),
        .o_right_addr (right_addr)
    );

    rtnc_line_mem u_line_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept && take),
        .i_rd_addr_a (item.col),
        .i_rd_addr_b (right_addr),
        .i_wr_en     (s1_adv),
        .i_wr_addr   (r_s1_item.col),
        .i_wr_data   (wr_data),
        .o_rd_entry  (rd_entry),
        .o_rd_right  (rd_right)
    );

    // Classify stage occupancy.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept && take) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && take) begin
            r_s1_item <= item;
        end
    end

    // Neighbour tests; cells outside the grid never count as river.
    always_comb begin
        centre         = rd_entry.middle;
        nb_t           = r_s1_item.top_ok && (rd_entry.upper == C_RIVER);
        nb_b           = r_s1_item.tile && (r_s1_item.code == C_RIVER);
        nb_l           = r_s1_item.left_ok && (r_left == C_RIVER);
        nb_r           = r_s1_item.right_ok && (rd_right == C_RIVER);
        wr_data.upper  = centre;
        wr_data.middle = r_s1_item.tile ? r_s1_item.code : centre;
    end

    // The centre of this column becomes the left neighbour of the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_adv) begin
            r_left <= centre;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_item.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_item.emit) begin
            r_class <= classify(centre, nb_t, nb_b, nb_l, nb_r);
            r_last  <= r_s1_item.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_class_code    = r_class;
    assign o_last_of_frame = r_last;

endmodule

@@ tb/sv/tb_river_tile_neighbour_classifier_top.sv @@
// Self-checking testbench of the river tile classifier with its own grid predictor.
module tb_river_tile_neighbour_classifier_top;

    import rtnc_pkg::*;

    localparam int IDLE_PERCENT  = 22;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 440;
    localparam int STEADY_WIDTH  = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam longint LIMIT_TIME = 64'd10_000_000;

    // Kind of one input transfer, as carried on i_mode.
    typedef enum bit {
        TILE_ITEM  = 1'b0,
        FLUSH_ITEM = 1'b1
    } t_item_kind;

    typedef struct {
        t_item_kind kind;
        t_code      code;
    } t_stream_item;

    typedef struct {
        t_code class_code;
        bit    last;
    } t_class_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_mode = 1'b0;
    logic [CODE_BITS-1:0]     i_tile_code = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [CODE_BITS-1:0]     o_class_code;
    logic                     o_last_of_frame;

    river_tile_neighbour_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_tile_code     (i_tile_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_class_code    (o_class_code),
        .o_last_of_frame (o_last_of_frame)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stream_item  tile_stream[$];
    t_class_result pending_classes[$];
    int unsigned   mismatches = 0;
    bit            steady_flow = 1'b0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;

    // Predictor state: line buffers, counters and the sizes last written.
    t_code       upper_row [MAX_COLUMNS];
    t_code       middle_row [MAX_COLUMNS];
    int unsigned col_pos = 0;
    t_row        rows_held = '0;
    t_code       prev_centre = '0;
    t_width      grid_width = t_width'(1);
    t_row        grid_height = t_row'(1);

    initial begin
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    // Rewrite one tile from its river neighbours; later patterns override earlier ones.
    function automatic t_code rewrite_tile(t_code centre, bit t, bit b, bit l, bit r);
        t_code v;
        v = centre;
        if (centre >= C_RIVER) begin
            if (t && l) v = C_NW_BEND;
            if (l && b) v = C_SW_BEND;
            if (t && r) v = C_NE_BEND;
            if (b && r) v = C_SE_BEND;
            if (b && r && t) v = C_NES_FORK;
            if (b && l && t) v = C_NSW_FORK;
            if (r && l && t) v = C_WNE_FORK;
            if (r && l && b) v = C_WSE_FORK;
            if (r && l && b && t) v = C_FOUR_WAY;
        end
        return v;
    endfunction

    // Advance the grid by one accepted transfer and queue the class it produces, if any.
    task automatic advance_grid(t_item_kind kind, t_code code);
        int unsigned w, h, c, out_row;
        bit          emit, t, b, l, r;
        t_code       centre, top, right;
        w = grid_width;
        h = grid_height;
        if (w < 1) w = 1;
        if (w > MAX_COLUMNS) w = MAX_COLUMNS;
        if (h < 1) h = 1;
        if (col_pos >= w) col_pos = 0;
        if (rows_held > h) rows_held = t_row'(h);
        c = col_pos;
        if (kind == TILE_ITEM) begin
            // A tile after the last row is in is dropped.
            if (rows_held >= h) return;
            emit    = (rows_held >= 1);
            out_row = emit ? rows_held - 1 : 0;
            b       = (code == C_RIVER);
        end else begin
            // A flush before the frame is complete is dropped.
            if (rows_held != h) return;
            emit    = 1'b1;
            out_row = h - 1;
            b       = 1'b0;
        end
        centre = middle_row[c];
        top    = upper_row[c];
        right  = (c + 1 < w) ? middle_row[c + 1] : t_code'(0);
        t = (out_row > 0) && (top == C_RIVER);
        l = (c > 0) && (prev_centre == C_RIVER);
        r = (c + 1 < w) && (right == C_RIVER);
        upper_row[c] = centre;
        if (kind == TILE_ITEM) middle_row[c] = code;
        prev_centre = centre;
        if (c + 1 >= w) begin
            col_pos   = 0;
            rows_held = (kind == TILE_ITEM) ? rows_held + 1'b1 : t_row'(0);
        end else begin
            col_pos = c + 1;
        end
        if (emit) begin
            pending_classes.push_back('{rewrite_tile(centre, t, b, l, r),
                                        (out_row == h - 1) && (c == w - 1)});
        end
    endtask

    // Driver: on each transfer update the predictor, then offer the next item or idle.
    always @(posedge i_clk) begin
        t_stream_item next_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) advance_grid(t_item_kind'(i_mode), i_tile_code);
            if (!i_in_valid || !o_in_stall) begin
                if (tile_stream.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
                    next_item = tile_stream.pop_front();
                    i_in_valid  <= 1'b1;
                    i_mode      <= next_item.kind;
                    i_tile_code <= next_item.code;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random idling, plus one long hold while the sender keeps offering.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && i_rst_n && tile_stream.size() > 40) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Monitor: compare each result transfer with the oldest predicted class.
    always @(posedge i_clk) begin
        t_class_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_classes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: class %0d last %0b",
                             o_class_code, o_last_of_frame);
            end else begin
                want = pending_classes.pop_front();
                if (o_class_code !== want.class_code || o_last_of_frame !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: class exp %0d got %0d, last exp %0b got %0b",
                                 want.class_code, o_class_code, want.last, o_last_of_frame);
                end
            end
        end
    end

    task automatic push_item(t_item_kind kind, t_code code);
        tile_stream.push_back('{kind, code});
    endtask

    function automatic t_code random_tile();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return C_RIVER;
        if (pick < 65) return t_code'(0);
        return t_code'($urandom_range(15));
    endfunction

    // Queue one whole frame; with noise, add dropped early flushes and tiles past the end.
    task automatic queue_frame(int unsigned w, int unsigned h, bit noisy);
        int unsigned extra;
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(99) < 4) push_item(FLUSH_ITEM, t_code'($urandom()));
            push_item(TILE_ITEM, random_tile());
        end
        extra = (noisy && $urandom_range(99) < 30) ? $urandom_range(1, 2) : 0;
        repeat (extra) push_item(TILE_ITEM, random_tile());
        repeat (w) push_item(FLUSH_ITEM, t_code'($urandom()));
    endtask

    // Register write through the configuration port; the predictor follows it.
    task automatic write_reg(t_cfg_idx index, int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= CFG_DATA_BITS'(value);
        if (index == CFG_GRID_WIDTH) grid_width = t_width'(value);
        else grid_height = t_row'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued item is taken and every predicted class has arrived.
    task automatic wait_idle();
        while (tile_stream.size() != 0 || i_in_valid || pending_classes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: directed frames, random frames at many sizes, then one frame without idling.
    initial begin
        int unsigned counted, w, h, w_eff, h_eff, frames;
        counted = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes (1x1): early flush dropped, tile past the end dropped.
        push_item(FLUSH_ITEM, t_code'(0));
        push_item(TILE_ITEM, t_code'(15));
        push_item(TILE_ITEM, t_code'(0));
        push_item(FLUSH_ITEM, t_code'(15));
        push_item(TILE_ITEM, t_code'(0));
        push_item(FLUSH_ITEM, t_code'(0));
        wait_idle();

        // A 3x3 river block yields every bend, every fork and the four-way code.
        write_reg(CFG_GRID_WIDTH, 3);
        write_reg(CFG_GRID_HEIGHT, 3);
        repeat (4) push_item(TILE_ITEM, C_RIVER);
        push_item(FLUSH_ITEM, C_RIVER);
        repeat (5) push_item(TILE_ITEM, C_RIVER);
        repeat (3) push_item(FLUSH_ITEM, t_code'(0));
        wait_idle();

        // Random sizes, mostly small, with zero sizes and unused width bits set.
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       w = 0;
                1:       w = 1;
                2:       w = 2;
                3:       w = $urandom_range(20, 48);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(7))
                0:       h = 0;
                1:       h = 1;
                2:       h = 2;
                default: h = $urandom_range(3, 6);
            endcase
            if ($urandom_range(1)) begin
                write_reg(CFG_GRID_WIDTH, w | ($urandom_range(7) << WIDTH_BITS));
                write_reg(CFG_GRID_HEIGHT, h);
            end else begin
                write_reg(CFG_GRID_HEIGHT, h);
                write_reg(CFG_GRID_WIDTH, w | ($urandom_range(7) << WIDTH_BITS));
            end
            w_eff = (w == 0) ? 1 : w;
            h_eff = (h == 0) ? 1 : h;
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                if (counted < RANDOM_ITEMS) begin
                    queue_frame(w_eff, h_eff, $urandom_range(99) < 70);
                    counted += w_eff * h_eff + w_eff;
                end
            end
            wait_idle();
        end

        // One wide frame run without idling on either side.
        steady_flow <= 1'b1;
        write_reg(CFG_GRID_WIDTH, STEADY_WIDTH);
        write_reg(CFG_GRID_HEIGHT, 3);
        queue_frame(STEADY_WIDTH, 3, 1'b0);
        wait_idle();
        steady_flow <= 1'b0;

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(LIMIT_TIME);
        $display("status: fail");
        $finish;
    end

endmodule
